// ===== sv/lsb_pkg.sv =====
// lottery scheduler package: word types, slot entry and constants
`timescale 1ns / 1ps
package lsb_pkg;

  typedef struct packed {
    logic       kind;
    logic [9:0] slot_index;
    logic [2:0] slot_status;
    logic [3:0] slot_priority;
    logic       current_valid;
    logic [9:0] current_index;
  } in_word_t;

  typedef struct packed {
    logic       chosen_valid;
    logic [9:0] chosen_index;
    logic [3:0] chosen_priority;
    logic       by_lottery;
    logic       boost_done;
  } out_word_t;

  typedef struct packed {
    logic [2:0] status;
    logic [3:0] prio;
  } entry_t;

  localparam logic [2:0]  ST_RUNNABLE = 3'd2;
  localparam logic [2:0]  ST_RUNNING  = 3'd3;
  localparam logic        KIND_WRITE  = 1'b1;

  localparam logic [31:0] LCG_MUL  = 32'd1103515245;
  localparam logic [31:0] LCG_ADD  = 32'd12345;
  localparam logic [15:0] SEED_RST = 16'd123;

  localparam logic [1:0] REG_TICKET_SCALE   = 2'd0;
  localparam logic [1:0] REG_BOOST_INTERVAL = 2'd1;
  localparam logic [1:0] REG_BOOST_LEVEL    = 2'd2;
  localparam logic [1:0] REG_RANDOM_MODULUS = 2'd3;

  localparam logic [15:0] TICKET_SCALE_RST   = 16'd11264;
  localparam logic [7:0]  BOOST_INTERVAL_RST = 8'd20;
  localparam logic [3:0]  BOOST_LEVEL_RST    = 4'd10;
  localparam logic [15:0] RANDOM_MODULUS_RST = 16'd32767;

endpackage

// ===== sv/lsb_div.sv =====
// lottery scheduler shared divider: restoring, one quotient bit per cycle
`timescale 1ns / 1ps
module lsb_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic        idle_o,
  output logic [31:0] quo_o,
  output logic [31:0] rem_o
);

  logic        busy_q;
  logic [4:0]  cnt_q;
  logic [31:0] quo_q;
  logic [31:0] rem_q;
  logic [31:0] div_q;
  logic [32:0] trial;
  logic        fits;

  assign trial = {rem_q, quo_q[31]};
  assign fits  = trial >= {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      quo_q  <= '0;
      rem_q  <= '0;
      div_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
      quo_q  <= dividend_i;
      rem_q  <= '0;
      div_q  <= divisor_i;
    end else if (busy_q) begin
      rem_q <= fits ? 32'(trial - {1'b0, div_q}) : trial[31:0];
      quo_q <= {quo_q[30:0], fits};
      cnt_q <= cnt_q + 5'd1;
      if (cnt_q == 5'd31) begin
        busy_q <= 1'b0;
      end
    end
  end

  assign idle_o = !busy_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule

// ===== sv/lsb_mem.sv =====
// lottery scheduler slot table: one write port, one registered read port
`timescale 1ns / 1ps
module lsb_mem #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AW-1:0]     waddr_i,
  input  lsb_pkg::entry_t   wdata_i,
  input  logic [AW-1:0]     raddr_i,
  output lsb_pkg::entry_t   rdata_o
);

  lsb_pkg::entry_t mem [DEPTH];
  lsb_pkg::entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/lottery_scheduler_with_boost.sv =====
// lottery scheduler with periodic priority boost, top level
`timescale 1ns / 1ps
// usage:
// input channel in_valid_i/in_ready_o carries one in_word_t per word; kind
// selects a slot write or a schedule request. every input word yields exactly
// one out_word_t on out_valid_o/out_ready_i, a write word gives all zeros.
// registers sit on the apb port at byte addresses 0, 4, 8 and 12: ticket
// scale, boost interval, boost level, random modulus; pready is always high.
// a slot write passes through the FINISH state to the output register and
// frees the input when its result is loaded there. a schedule request walks
// the slot table through its single read port up to three times (sum,
// selection, boost) and runs up to 18 divisions on the shared divider.
// after reset the table is swept to zero, one slot a cycle, so in_ready_o
// stays low until the sweep ends. one word is in work at a time; a finished
// result waits in the output register while the next word is taken, and a
// stalled receiver only holds off the result after that.
module lottery_scheduler_with_boost #(
  parameter int unsigned NUM_SLOTS = 1024
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  lsb_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output lsb_pkg::out_word_t out_word_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int unsigned AW = $clog2(NUM_SLOTS);
  localparam int unsigned TW = $clog2(NUM_SLOTS * 16 + 1);
  localparam logic [AW:0] CNT_END  = (AW+1)'(NUM_SLOTS);
  localparam logic [AW:0] CNT_LAST = (AW+1)'(NUM_SLOTS - 1);

  typedef enum logic [3:0] {
    CLEAR, IDLE, SUM, LCG_MUL, LCG_DIV, WIN_DIV, TK_DIV, SEL,
    BCHK, BOOST, FIX, FIX_RD, FIX_WR, FINISH
  } state_e;

  state_e             state_q;
  logic [AW:0]        cnt_q;
  logic               pv_q;
  logic [AW-1:0]      pa_q;
  logic [TW-1:0]      total_q;
  logic [15:0]        seed_q;
  logic [31:0]        lcgv_q;
  logic [15:0]        win_q;
  logic [3:0]         tk_q;
  logic [15:0]        tick_q [16];
  logic [16:0]        acc_q;
  logic               found_q;
  logic [AW-1:0]      widx_q;
  logic               cur_valid_q;
  logic [9:0]         cur_idx_q;
  logic [7:0]         calls_q;
  logic               boost_q;
  logic               launched_q;
  lsb_pkg::out_word_t res_q;
  lsb_pkg::out_word_t out_word_q;
  logic               out_valid_q;

  logic [15:0] scale_q;
  logic [7:0]  interval_q;
  logic [3:0]  level_q;
  logic [15:0] rmod_q;

  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  lsb_pkg::entry_t mem_wdata;
  logic [AW-1:0]   mem_raddr;
  lsb_pkg::entry_t rd;

  logic        div_start;
  logic [31:0] div_a;
  logic [31:0] div_b;
  logic        div_idle;
  logic [31:0] div_quo;
  logic [31:0] div_rem;

  logic        in_fire;
  logic        wr_ok;
  logic        cur_ok;
  logic        issue;
  logic        runnable;
  logic        running;
  logic [31:0] lcg_v;
  logic [4:0]  tk_k;
  logic [20:0] tk_num;
  logic [16:0] acc_n;
  logic [7:0]  calls_n;
  logic [3:0]  dec;
  logic        fix_ok;
  logic        tk_take;

  assign in_ready_o = state_q == IDLE;
  assign in_fire    = in_valid_i && in_ready_o;
  assign wr_ok      = 32'(in_word_i.slot_index) < 32'(NUM_SLOTS);
  assign cur_ok     = cur_valid_q && (32'(cur_idx_q) < 32'(NUM_SLOTS));
  assign issue      = (cnt_q != CNT_END) && !(state_q == SEL && found_q);
  assign runnable   = rd.status == lsb_pkg::ST_RUNNABLE;
  assign running    = rd.status == lsb_pkg::ST_RUNNING;
  assign lcg_v      = lsb_pkg::LCG_MUL * 32'(seed_q) + lsb_pkg::LCG_ADD;
  assign tk_k       = 5'(tk_q) + 5'd1;
  assign tk_num     = 21'(tk_k) * 21'(scale_q);
  assign acc_n      = acc_q + 17'(tick_q[rd.prio]);
  assign calls_n    = calls_q + 8'd1;
  assign dec        = (rd.prio == 4'd0) ? 4'd0 : rd.prio - 4'd1;
  assign fix_ok     = found_q || running;
  assign tk_take    = state_q == TK_DIV && launched_q && div_idle;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cnt_q[AW-1:0];
    mem_wdata = '0;
    mem_raddr = cnt_q[AW-1:0];
    div_start = 1'b0;
    div_a     = '0;
    div_b     = '0;
    unique case (state_q)
      CLEAR: begin
        mem_we = 1'b1;
      end
      IDLE: begin
        if (in_fire && in_word_i.kind == lsb_pkg::KIND_WRITE && wr_ok) begin
          mem_we    = 1'b1;
          mem_waddr = AW'(in_word_i.slot_index);
          mem_wdata = {in_word_i.slot_status, in_word_i.slot_priority};
        end
      end
      LCG_DIV: begin
        div_a     = lcgv_q;
        div_b     = {16'd0, rmod_q};
        div_start = !launched_q && rmod_q != 16'd0;
      end
      WIN_DIV: begin
        div_a     = {16'd0, seed_q};
        div_b     = {16'd0, scale_q};
        div_start = !launched_q && scale_q != 16'd0;
      end
      TK_DIV: begin
        div_a     = 32'(tk_num);
        div_b     = 32'(total_q);
        div_start = !launched_q;
      end
      BOOST: begin
        if (pv_q && (runnable || running)) begin
          mem_we    = 1'b1;
          mem_waddr = pa_q;
          mem_wdata = {rd.status, level_q};
        end
      end
      FIX_RD: begin
        mem_raddr = found_q ? widx_q : AW'(cur_idx_q);
      end
      FIX_WR: begin
        if (fix_ok) begin
          mem_we    = 1'b1;
          mem_waddr = pa_q;
          mem_wdata = {rd.status, dec};
        end
      end
      default: ;
    endcase
  end

  lsb_mem #(
    .DEPTH(NUM_SLOTS),
    .AW   (AW)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .raddr_i(mem_raddr),
    .rdata_o(rd)
  );

  lsb_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_a),
    .divisor_i (div_b),
    .idle_o    (div_idle),
    .quo_o     (div_quo),
    .rem_o     (div_rem)
  );

  always_ff @(posedge clk_i) begin
    if (tk_take) begin
      tick_q[tk_q] <= div_quo[15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= CLEAR;
      cnt_q       <= '0;
      pv_q        <= 1'b0;
      pa_q        <= '0;
      total_q     <= '0;
      seed_q      <= lsb_pkg::SEED_RST;
      lcgv_q      <= '0;
      win_q       <= '0;
      tk_q        <= '0;
      acc_q       <= '0;
      found_q     <= 1'b0;
      widx_q      <= '0;
      cur_valid_q <= 1'b0;
      cur_idx_q   <= '0;
      calls_q     <= '0;
      boost_q     <= 1'b0;
      launched_q  <= 1'b0;
      res_q       <= '0;
      out_word_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i && state_q != FINISH) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        CLEAR: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CNT_LAST) begin
            cnt_q   <= '0;
            state_q <= IDLE;
          end
        end
        IDLE: begin
          if (in_fire) begin
            if (in_word_i.kind == lsb_pkg::KIND_WRITE) begin
              res_q   <= '0;
              state_q <= FINISH;
            end else begin
              cur_valid_q <= in_word_i.current_valid;
              cur_idx_q   <= in_word_i.current_index;
              cnt_q       <= '0;
              pv_q        <= 1'b0;
              total_q     <= '0;
              found_q     <= 1'b0;
              boost_q     <= 1'b0;
              state_q     <= SUM;
            end
          end
        end
        SUM: begin
          pv_q <= issue;
          pa_q <= cnt_q[AW-1:0];
          if (issue) begin
            cnt_q <= cnt_q + 1'b1;
          end
          if (pv_q && runnable) begin
            total_q <= total_q + TW'(rd.prio) + TW'(1);
          end
          if (!issue && !pv_q) begin
            state_q <= LCG_MUL;
          end
        end
        LCG_MUL: begin
          lcgv_q     <= lcg_v;
          launched_q <= 1'b0;
          state_q    <= LCG_DIV;
        end
        LCG_DIV: begin
          if (rmod_q == 16'd0) begin
            seed_q  <= '0;
            state_q <= WIN_DIV;
          end else if (!launched_q) begin
            launched_q <= 1'b1;
          end else if (div_idle) begin
            seed_q     <= div_rem[15:0];
            launched_q <= 1'b0;
            state_q    <= WIN_DIV;
          end
        end
        WIN_DIV: begin
          if (scale_q == 16'd0 || (launched_q && div_idle)) begin
            win_q      <= (scale_q == 16'd0) ? 16'd0 : div_rem[15:0];
            launched_q <= 1'b0;
            tk_q       <= '0;
            state_q    <= (total_q == '0) ? BCHK : TK_DIV;
          end else if (!launched_q) begin
            launched_q <= 1'b1;
          end
        end
        TK_DIV: begin
          if (!launched_q) begin
            launched_q <= 1'b1;
          end else if (div_idle) begin
            launched_q <= 1'b0;
            tk_q       <= tk_q + 4'd1;
            if (tk_q == 4'd15) begin
              cnt_q   <= '0;
              pv_q    <= 1'b0;
              acc_q   <= '0;
              state_q <= SEL;
            end
          end
        end
        SEL: begin
          pv_q <= issue;
          pa_q <= cnt_q[AW-1:0];
          if (issue) begin
            cnt_q <= cnt_q + 1'b1;
          end
          if (pv_q && runnable && !found_q) begin
            acc_q <= acc_n;
            if (acc_n >= {1'b0, win_q}) begin
              found_q <= 1'b1;
              widx_q  <= pa_q;
              state_q <= BCHK;
            end
          end
          if (!issue && !pv_q) begin
            state_q <= BCHK;
          end
        end
        BCHK: begin
          cnt_q <= '0;
          pv_q  <= 1'b0;
          if (calls_n >= interval_q) begin
            calls_q <= '0;
            boost_q <= 1'b1;
            state_q <= BOOST;
          end else begin
            calls_q <= calls_n;
            state_q <= FIX;
          end
        end
        BOOST: begin
          pv_q <= issue;
          pa_q <= cnt_q[AW-1:0];
          if (issue) begin
            cnt_q <= cnt_q + 1'b1;
          end
          if (!issue && !pv_q) begin
            state_q <= FIX;
          end
        end
        FIX: begin
          if (found_q || cur_ok) begin
            state_q <= FIX_RD;
          end else begin
            res_q   <= '{chosen_valid: 1'b0, chosen_index: '0, chosen_priority: '0,
                         by_lottery: 1'b0, boost_done: boost_q};
            state_q <= FINISH;
          end
        end
        FIX_RD: begin
          pa_q    <= mem_raddr;
          state_q <= FIX_WR;
        end
        FIX_WR: begin
          if (fix_ok) begin
            res_q <= '{chosen_valid: 1'b1, chosen_index: 10'(pa_q), chosen_priority: dec,
                       by_lottery: found_q, boost_done: boost_q};
          end else begin
            res_q <= '{chosen_valid: 1'b0, chosen_index: '0, chosen_priority: '0,
                       by_lottery: 1'b0, boost_done: boost_q};
          end
          state_q <= FINISH;
        end
        FINISH: begin
          if (!out_valid_q || out_ready_i) begin
            out_word_q  <= res_q;
            out_valid_q <= 1'b1;
            state_q     <= IDLE;
          end
        end
        default: state_q <= IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  // register port
  logic cfg_we;
  assign cfg_we = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q    <= lsb_pkg::TICKET_SCALE_RST;
      interval_q <= lsb_pkg::BOOST_INTERVAL_RST;
      level_q    <= lsb_pkg::BOOST_LEVEL_RST;
      rmod_q     <= lsb_pkg::RANDOM_MODULUS_RST;
    end else if (cfg_we) begin
      unique case (paddr[3:2])
        lsb_pkg::REG_TICKET_SCALE:   scale_q    <= pwdata[15:0];
        lsb_pkg::REG_BOOST_INTERVAL: interval_q <= pwdata[7:0];
        lsb_pkg::REG_BOOST_LEVEL:    level_q    <= pwdata[3:0];
        lsb_pkg::REG_RANDOM_MODULUS: rmod_q     <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      lsb_pkg::REG_TICKET_SCALE:   prdata = {16'd0, scale_q};
      lsb_pkg::REG_BOOST_INTERVAL: prdata = {24'd0, interval_q};
      lsb_pkg::REG_BOOST_LEVEL:    prdata = {28'd0, level_q};
      lsb_pkg::REG_RANDOM_MODULUS: prdata = {16'd0, rmod_q};
      default:                     prdata = '0;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_no_write_in_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SUM || state_q == SEL) |-> !mem_we)
    else $error("table written during a read-only walk");

  a_div_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> div_idle)
    else $error("divider started while busy");

  a_write_word_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_word_i.kind == lsb_pkg::KIND_WRITE) |=> state_q == FINISH)
    else $error("write word did not go straight to result");

  a_boost_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BCHK && calls_n >= interval_q) |=> (calls_q == 8'd0 && boost_q))
    else $error("boost did not clear call count");
`endif

endmodule

// ===== tb/sv/lottery_scheduler_with_boost_tb.sv =====
// testbench for the lottery scheduler: directed table, then random words checked by a predictor
`timescale 1ns / 1ps
module lottery_scheduler_with_boost_tb;

  localparam logic KIND_SCHED = 1'b0;
  localparam int   SLOTS      = 1024;
  localparam int   DIR_ROWS   = 20;

  typedef struct {
    lsb_pkg::in_word_t  w;
    logic               typed;
    lsb_pkg::out_word_t want;
  } dir_row_t;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  lsb_pkg::in_word_t  in_word_i;
  logic               out_valid_o;
  logic               out_ready_i;
  lsb_pkg::out_word_t out_word_o;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [3:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  lottery_scheduler_with_boost u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_word_o (out_word_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  // shadow of the slot table, draw state and registers
  logic [2:0]  slot_status_q [SLOTS];
  logic [3:0]  slot_prio_q [SLOTS];
  logic [31:0] seed_q;
  logic [7:0]  calls_q;
  logic [15:0] scale_q;
  logic [7:0]  interval_q;
  logic [3:0]  level_q;
  logic [15:0] modulus_q;

  lsb_pkg::out_word_t pending_q [$];
  int                 errors;
  int                 idle_mode;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #100_000_000;
    $display("lottery_scheduler_with_boost_tb: FAIL");
    $finish;
  end

  function automatic lsb_pkg::out_word_t sched_predict(lsb_pkg::in_word_t w);
    lsb_pkg::out_word_t res;
    logic [31:0]        total;
    logic [31:0]        acc;
    logic [31:0]        lcg;
    logic [31:0]        winning;
    logic               found;
    logic [9:0]         pick;
    res = '0;
    total = 0;
    acc = 0;
    found = 1'b0;
    pick = '0;
    if (w.kind == lsb_pkg::KIND_WRITE) begin
      slot_status_q[w.slot_index] = w.slot_status;
      slot_prio_q[w.slot_index] = w.slot_priority;
      return res;
    end
    for (int i = 0; i < SLOTS; i++) begin
      if (slot_status_q[i] == lsb_pkg::ST_RUNNABLE) total += slot_prio_q[i] + 32'd1;
    end
    lcg = lsb_pkg::LCG_MUL * seed_q + lsb_pkg::LCG_ADD;
    seed_q = (modulus_q != 0) ? lcg % modulus_q : 32'd0;
    winning = (scale_q != 0) ? seed_q % scale_q : 32'd0;
    if (total != 0) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (!found && slot_status_q[i] == lsb_pkg::ST_RUNNABLE) begin
          acc += (slot_prio_q[i] + 32'd1) * scale_q / total;
          if (acc >= winning) begin
            found = 1'b1;
            res.by_lottery = 1'b1;
            pick = i[9:0];
          end
        end
      end
    end
    calls_q = calls_q + 8'd1;
    if (calls_q >= interval_q) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (slot_status_q[i] == lsb_pkg::ST_RUNNABLE ||
            slot_status_q[i] == lsb_pkg::ST_RUNNING)
          slot_prio_q[i] = level_q;
      end
      calls_q = '0;
      res.boost_done = 1'b1;
    end
    if (!found && w.current_valid &&
        slot_status_q[w.current_index] == lsb_pkg::ST_RUNNING) begin
      found = 1'b1;
      pick = w.current_index;
    end
    if (found) begin
      if (slot_prio_q[pick] != 0) slot_prio_q[pick] = slot_prio_q[pick] - 4'd1;
      res.chosen_valid = 1'b1;
      res.chosen_index = pick;
      res.chosen_priority = slot_prio_q[pick];
    end
    return res;
  endfunction

  function automatic lsb_pkg::in_word_t random_word();
    lsb_pkg::in_word_t w;
    w.slot_priority = 4'($urandom_range(0, 15));
    w.current_valid = 1'($urandom_range(0, 1));
    w.current_index = 10'($urandom_range(0, 1023));
    if ($urandom_range(0, 99) < 25) begin
      w.kind = KIND_SCHED;
      w.slot_index = 10'($urandom_range(0, 1023));
      w.slot_status = 3'($urandom_range(0, 7));
      w.current_valid = ($urandom_range(0, 99) < 75);
      if ($urandom_range(0, 99) < 70) w.current_index = 10'($urandom_range(0, 15));
    end else begin
      w.kind = lsb_pkg::KIND_WRITE;
      w.slot_index = ($urandom_range(0, 99) < 70) ? 10'($urandom_range(0, 15))
                                                  : 10'($urandom_range(0, 1023));
      w.slot_status = ($urandom_range(0, 99) < 75) ? 3'($urandom_range(2, 3))
                                                   : 3'($urandom_range(0, 7));
    end
    return w;
  endfunction

  task automatic send_word(lsb_pkg::in_word_t w, logic typed, lsb_pkg::out_word_t want);
    lsb_pkg::out_word_t pred;
    logic               rdy;
    int                 gap_pct;
    gap_pct = (idle_mode == 0) ? 34 : (idle_mode == 1) ? 62 : 0;
    if ($urandom_range(0, 99) < gap_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < gap_pct);
    end
    in_valid_i <= 1'b1;
    in_word_i <= w;
    do begin
      @(negedge clk_i);
      rdy = in_ready_o;
      @(posedge clk_i);
    end while (!rdy);
    pred = sched_predict(w);
    pending_q.push_back(typed ? want : pred);
  endtask

  task automatic reg_write(logic [1:0] idx, logic [31:0] val);
    @(posedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      lsb_pkg::REG_TICKET_SCALE:   scale_q = val[15:0];
      lsb_pkg::REG_BOOST_INTERVAL: interval_q = val[7:0];
      lsb_pkg::REG_BOOST_LEVEL:    level_q = val[3:0];
      lsb_pkg::REG_RANDOM_MODULUS: modulus_q = val[15:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_regs(logic [15:0] sc, logic [7:0] iv, logic [3:0] lv, logic [15:0] md);
    drain();
    reg_write(lsb_pkg::REG_TICKET_SCALE, {16'd0, sc});
    reg_write(lsb_pkg::REG_BOOST_INTERVAL, {24'd0, iv});
    reg_write(lsb_pkg::REG_BOOST_LEVEL, {28'd0, lv});
    reg_write(lsb_pkg::REG_RANDOM_MODULUS, {16'd0, md});
  endtask

  // result side: random stall, compare with oldest expectation
  initial begin
    lsb_pkg::out_word_t got;
    lsb_pkg::out_word_t want;
    logic               vld;
    logic               rdy;
    int                 stall_pct;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      vld = out_valid_o;
      rdy = out_ready_i;
      got = out_word_o;
      @(posedge clk_i);
      if (rst_ni && vld && rdy) begin
        if (pending_q.size() == 0) begin
          $error("result word with nothing expected");
          errors++;
        end else begin
          want = pending_q.pop_front();
          if (got.chosen_valid !== want.chosen_valid) begin
            $error("chosen_valid exp %0d got %0d", want.chosen_valid, got.chosen_valid);
            errors++;
          end
          if (got.chosen_index !== want.chosen_index) begin
            $error("chosen_index exp %0d got %0d", want.chosen_index, got.chosen_index);
            errors++;
          end
          if (got.chosen_priority !== want.chosen_priority) begin
            $error("chosen_priority exp %0d got %0d", want.chosen_priority,
                   got.chosen_priority);
            errors++;
          end
          if (got.by_lottery !== want.by_lottery) begin
            $error("by_lottery exp %0d got %0d", want.by_lottery, got.by_lottery);
            errors++;
          end
          if (got.boost_done !== want.boost_done) begin
            $error("boost_done exp %0d got %0d", want.boost_done, got.boost_done);
            errors++;
          end
        end
      end
      stall_pct = (idle_mode == 0) ? 62 : (idle_mode == 1) ? 34 : 0;
      out_ready_i <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  initial begin
    dir_row_t           dir_tab [DIR_ROWS];
    lsb_pkg::out_word_t fallback_top;
    int                 timer;
    fallback_top = '{1'b1, 10'd1023, 4'd0, 1'b0, 1'b0};
    dir_tab = '{
      // empty table: nothing runs
      '{'{KIND_SCHED, 10'd0,    3'd0, 4'd0,  1'b1, 10'd1023}, 1'b1, '0},
      '{'{lsb_pkg::KIND_WRITE, 10'd1023, 3'd7, 4'd15, 1'b1, 10'd1023}, 1'b1, '0},
      // unknown status is not running
      '{'{KIND_SCHED, 10'd1023, 3'd7, 4'd15, 1'b1, 10'd1023}, 1'b1, '0},
      '{'{lsb_pkg::KIND_WRITE, 10'd1023, lsb_pkg::ST_RUNNING, 4'd0, 1'b0, 10'd0}, 1'b1, '0},
      // fallback to current slot, priority floor at zero
      '{'{KIND_SCHED, 10'd0,    3'd0, 4'd0,  1'b1, 10'd1023}, 1'b1, fallback_top},
      '{'{KIND_SCHED, 10'd0,    3'd0, 4'd0,  1'b0, 10'd1023}, 1'b0, '0},
      '{'{lsb_pkg::KIND_WRITE, 10'd0,   lsb_pkg::ST_RUNNABLE, 4'd15, 1'b0, 10'd0}, 1'b1, '0},
      '{'{lsb_pkg::KIND_WRITE, 10'd512, lsb_pkg::ST_RUNNABLE, 4'd0,  1'b1, 10'd5}, 1'b1, '0},
      '{'{lsb_pkg::KIND_WRITE, 10'd1,    3'd4, 4'd5,  1'b0, 10'd0}, 1'b1, '0},
      '{'{lsb_pkg::KIND_WRITE, 10'd2,    3'd1, 4'd3,  1'b0, 10'd0}, 1'b1, '0},
      '{'{lsb_pkg::KIND_WRITE, 10'd3,    3'd5, 4'd9,  1'b0, 10'd0}, 1'b1, '0},
      '{'{lsb_pkg::KIND_WRITE, 10'd4,    3'd6, 4'd8,  1'b0, 10'd0}, 1'b1, '0},
      '{'{KIND_SCHED, 10'd0,    3'd0, 4'd0,  1'b1, 10'd1023}, 1'b0, '0},
      '{'{KIND_SCHED, 10'd1023, 3'd7, 4'd15, 1'b1, 10'd3}, 1'b0, '0},
      '{'{KIND_SCHED, 10'd0,    3'd0, 4'd0,  1'b0, 10'd0}, 1'b0, '0},
      '{'{lsb_pkg::KIND_WRITE, 10'd0,    3'd0, 4'd0,  1'b0, 10'd0}, 1'b1, '0},
      '{'{KIND_SCHED, 10'd0,    3'd0, 4'd0,  1'b1, 10'd1023}, 1'b0, '0},
      '{'{lsb_pkg::KIND_WRITE, 10'd512,  3'd0, 4'd0,  1'b0, 10'd0}, 1'b1, '0},
      '{'{KIND_SCHED, 10'd0,    3'd0, 4'd0,  1'b1, 10'd1023}, 1'b0, '0},
      '{'{lsb_pkg::KIND_WRITE, 10'd1023, 3'd0, 4'd0,  1'b0, 10'd0}, 1'b1, '0}
    };
    errors = 0;
    idle_mode = 2;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_word_i = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    for (int i = 0; i < SLOTS; i++) begin
      slot_status_q[i] = '0;
      slot_prio_q[i] = '0;
    end
    seed_q = 32'(lsb_pkg::SEED_RST);
    calls_q = '0;
    scale_q = lsb_pkg::TICKET_SCALE_RST;
    interval_q = lsb_pkg::BOOST_INTERVAL_RST;
    level_q = lsb_pkg::BOOST_LEVEL_RST;
    modulus_q = lsb_pkg::RANDOM_MODULUS_RST;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int r = 0; r < DIR_ROWS; r++) send_word(dir_tab[r].w, dir_tab[r].typed, dir_tab[r].want);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: set_regs(16'd65535, 8'd1, 4'd15, 16'd65535);
        1: set_regs(16'd0, 8'd0, 4'd0, 16'd0);
        2: set_regs(16'd1, 8'd255, 4'd0, 16'd1);
        default: set_regs(16'($urandom_range(1, 65535)), 8'($urandom_range(1, 12)),
                          4'($urandom_range(0, 15)), 16'($urandom_range(1, 65535)));
      endcase
      idle_mode = (ph < 3) ? ph : 2;
      for (int k = 0; k < 63; k++) send_word(random_word(), 1'b0, '0);
    end

    in_valid_i <= 1'b0;
    timer = 0;
    while (pending_q.size() != 0 && timer < 200_000) begin
      @(posedge clk_i);
      timer++;
    end
    repeat (50) @(posedge clk_i);
    if (errors == 0 && pending_q.size() == 0) begin
      $display("lottery_scheduler_with_boost_tb: PASS");
    end else begin
      $display("lottery_scheduler_with_boost_tb: FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/lsb_pkg.sv
sv/lsb_div.sv
sv/lsb_mem.sv
sv/lottery_scheduler_with_boost.sv
tb/sv/lottery_scheduler_with_boost_tb.sv
